// ===== hdl/subresource_state_barrier_tracker_assert.svh =====
// Assertion macros for the subresource barrier tracker.
`ifndef SUBRESOURCE_STATE_BARRIER_TRACKER_ASSERT_SVH
`define SUBRESOURCE_STATE_BARRIER_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SSBT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SSBT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ssbt_pkg.sv =====
// Shared constants for the subresource barrier tracker.
`timescale 1ns / 1ps

package ssbt_pkg;

	localparam int SUB_CNT = 16;
	localparam int SUB_W   = $clog2(SUB_CNT);
	localparam int STATE_W = 32;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [STATE_W-1:0] UAV_STATE = 32'h0000_0008;

	localparam logic KIND_TRANSITION = 1'b0;
	localparam logic KIND_UAV        = 1'b1;

	localparam logic REG_RESOURCE_BOUND = 1'b0;

endpackage

// ===== hdl/subresource_state_barrier_tracker.sv =====
// Subresource usage-state tracker: scans a 16-entry state table and emits barrier words.
// Single-entry request: busy only in ST_SINGLE, which compares the entry and registers its word.
// Whole-resource request: ST_SCAN compares every entry through the shared compare unit, then
// ST_RESOLVE emits at most one word on a uniform table, else a walk emits one word per
// differing entry. A new request is accepted only when the tracker is idle.
// Words cannot be stalled. Reset clears the table to zero and resource_bound to 0.
`timescale 1ns / 1ps
`include "subresource_state_barrier_tracker_assert.svh"

module subresource_state_barrier_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          all_subresources,
	input  logic [ssbt_pkg::SUB_W-1:0]    subresource_index,
	input  logic [ssbt_pkg::STATE_W-1:0]  target_usage,
	output logic                          barrier_valid,
	output logic                          barrier_kind,
	output logic [ssbt_pkg::STATE_W-1:0]  state_before,
	output logic [ssbt_pkg::STATE_W-1:0]  state_after,
	output logic                          covers_all,
	output logic [ssbt_pkg::SUB_W-1:0]    barrier_subresource,
	output logic                          last_barrier,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssbt_pkg::ADDR_W-1:0]   paddr,
	input  logic [ssbt_pkg::DATA_W-1:0]   pwdata,
	output logic [ssbt_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import ssbt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SINGLE,
		ST_SCAN,
		ST_RESOLVE,
		ST_WALK
	} fsm_t;

	fsm_t                 state_q;
	logic [STATE_W-1:0]   table_q [SUB_CNT];
	logic                 bound_q;
	logic [SUB_W-1:0]     cnt_q;
	logic [SUB_W-1:0]     idx_q;
	logic [STATE_W-1:0]   tgt_q;
	logic                 same_q;
	logic [SUB_CNT-1:0]   diff_q;

	logic                 valid_q;
	logic                 kind_q;
	logic [STATE_W-1:0]   before_q;
	logic [STATE_W-1:0]   after_q;
	logic                 all_q;
	logic [SUB_W-1:0]     sub_q;
	logic                 last_q;

	logic                 accept;
	logic                 cfg_wr;
	logic [SUB_W-1:0]     rd_idx;
	logic [STATE_W-1:0]   rd_data;
	logic                 eq_tgt;
	logic                 eq_first;
	logic [SUB_CNT-1:0]   remain;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1] == REG_RESOURCE_BOUND) begin
			prdata[0] = bound_q;
		end
	end

	// Shared comparator: one table read per cycle, checked against target and entry 0
	assign rd_idx   = (state_q == ST_SINGLE) ? idx_q : cnt_q;
	assign rd_data  = table_q[rd_idx];
	assign eq_tgt   = (rd_data == tgt_q);
	assign eq_first = (rd_data == table_q[0]);
	assign remain   = diff_q & ~(SUB_CNT'(1) << cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			bound_q  <= 1'b0;
			cnt_q    <= '0;
			idx_q    <= '0;
			tgt_q    <= '0;
			same_q   <= 1'b1;
			diff_q   <= '0;
			valid_q  <= 1'b0;
			kind_q   <= KIND_TRANSITION;
			before_q <= '0;
			after_q  <= '0;
			all_q    <= 1'b0;
			sub_q    <= '0;
			last_q   <= 1'b0;
			for (int i = 0; i < SUB_CNT; i++) begin
				table_q[i] <= '0;
			end
		end else begin
			valid_q <= 1'b0;
			if (cfg_wr && paddr[ADDR_W-1] == REG_RESOURCE_BOUND) begin
				bound_q <= pwdata[0];
			end
			unique case (state_q)
				ST_IDLE: begin
					// drop requests while no resource is attached
					if (accept && bound_q) begin
						idx_q  <= subresource_index;
						tgt_q  <= target_usage;
						cnt_q  <= '0;
						same_q <= 1'b1;
						diff_q <= '0;
						state_q <= all_subresources ? ST_SCAN : ST_SINGLE;
					end
				end
				ST_SINGLE: begin
					if (!eq_tgt) begin
						valid_q  <= 1'b1;
						kind_q   <= KIND_TRANSITION;
						before_q <= rd_data;
						after_q  <= tgt_q;
						all_q    <= 1'b0;
						sub_q    <= idx_q;
						last_q   <= 1'b1;
						table_q[idx_q] <= tgt_q;
					end else if (tgt_q == UAV_STATE) begin
						valid_q  <= 1'b1;
						kind_q   <= KIND_UAV;
						before_q <= '0;
						after_q  <= '0;
						all_q    <= 1'b1;
						sub_q    <= '0;
						last_q   <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (!eq_first) begin
						same_q <= 1'b0;
					end
					diff_q[cnt_q] <= !eq_tgt;
					// counter wraps to entry 0 for the resolve step
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SUB_W'(SUB_CNT - 1)) begin
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					if (same_q) begin
						if (!eq_tgt) begin
							valid_q  <= 1'b1;
							kind_q   <= KIND_TRANSITION;
							before_q <= rd_data;
							after_q  <= tgt_q;
							all_q    <= 1'b1;
							sub_q    <= '0;
							last_q   <= 1'b1;
							for (int i = 0; i < SUB_CNT; i++) begin
								table_q[i] <= tgt_q;
							end
						end else if (tgt_q == UAV_STATE) begin
							valid_q  <= 1'b1;
							kind_q   <= KIND_UAV;
							before_q <= '0;
							after_q  <= '0;
							all_q    <= 1'b1;
							sub_q    <= '0;
							last_q   <= 1'b1;
						end
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (diff_q[cnt_q]) begin
						valid_q  <= 1'b1;
						kind_q   <= KIND_TRANSITION;
						before_q <= rd_data;
						after_q  <= tgt_q;
						all_q    <= 1'b0;
						sub_q    <= cnt_q;
						last_q   <= (remain == '0);
						table_q[cnt_q] <= tgt_q;
					end
					diff_q <= remain;
					cnt_q  <= cnt_q + 1'b1;
					// stop as soon as no differing entry is left
					if (remain == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign barrier_valid       = valid_q;
	assign barrier_kind        = kind_q;
	assign state_before        = before_q;
	assign state_after         = after_q;
	assign covers_all          = all_q;
	assign barrier_subresource = sub_q;
	assign last_barrier        = last_q;

	`SSBT_ASSERT_SAME(a_uav_shape, barrier_valid && barrier_kind == KIND_UAV,
		last_barrier && covers_all && state_before == '0, "malformed uav word")
	`SSBT_ASSERT_SAME(a_transition_changes, barrier_valid && barrier_kind == KIND_TRANSITION,
		state_before != state_after, "transition word without a state change")
	`SSBT_ASSERT_NEXT(a_last_ends, barrier_valid && last_barrier,
		!barrier_valid, "word after the last one of a request")
	`SSBT_ASSERT_NEXT(a_unbound_drop, accept && !bound_q,
		!busy && !barrier_valid, "request taken while no resource is bound")
	`SSBT_ASSERT_SAME(a_walk_pending, state_q == ST_WALK,
		diff_q != '0, "walk with no differing entry left")

endmodule
